// ----- sv/csfe_pkg.sv -----
package csfe_pkg;

	localparam int UNIT_W = 16;
	localparam logic signed [UNIT_W-1:0] UNIT_ONE = 16'sd16384;

	localparam int SQ_W = 62;
	localparam int ROOT_W = 31;
	localparam int DEN_W = 33;

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_EVAL = 1'b1;

	localparam logic [1:0] REG_STEP_COUNT  = 2'd0;
	localparam logic [1:0] REG_BASIS_MODE  = 2'd1;
	localparam logic [1:0] REG_PLANAR_MODE = 2'd2;

	typedef logic signed [UNIT_W-1:0] unit_t;
	typedef unit_t uvec_t [3];

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	function automatic logic [1:0] axis_next(input logic [1:0] a);
		logic [1:0] r;
		r = (a == 2'd2) ? 2'd0 : a + 2'd1;
		return r;
	endfunction

endpackage

// ----- sv/csfe_div.sv -----
module csfe_div
	import csfe_pkg::*;
#(
	parameter int NUM_W = 63
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [NUM_W-1:0] quo,
	output unit_stat_t       stat
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [DEN_W:0]   rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   rem_sh;
	logic [DEN_W:0]   rem_nx;
	logic             ge;

	always_comb begin
		rem_sh = {rem_q[DEN_W-1:0], quo_q[NUM_W-1]};
		ge = rem_sh >= {1'b0, den_q};
		rem_nx = ge ? rem_sh - {1'b0, den_q} : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign quo = quo_q;
	assign stat = '{busy: busy_q, done: done_q};

endmodule

// ----- sv/csfe_sqrt.sv -----
module csfe_sqrt
	import csfe_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SQ_W-1:0]   radicand,
	output logic [ROOT_W-1:0] root,
	output unit_stat_t        stat
);

	localparam int CNT_W = $clog2(ROOT_W + 1);

	logic [SQ_W-1:0]  x_q;
	logic [SQ_W-1:0]  res_q;
	logic [SQ_W-1:0]  bit_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [SQ_W-1:0]  trial;
	logic             ge;

	always_comb begin
		trial = res_q + bit_q;
		ge = x_q >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(ROOT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= radicand;
			res_q <= '0;
			bit_q <= SQ_W'(1) << (SQ_W - 2);
		end else if (busy_q) begin
			if (ge) begin
				x_q <= x_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign root = res_q[ROOT_W-1:0];
	assign stat = '{busy: busy_q, done: done_q};

endmodule

// ----- sv/cubic_spline_frame_evaluator_core.sv -----
// A load beat is taken in S_IDLE and gives no result; the next beat is taken right after.
// An evaluate beat gives one result beat; it runs longer by each shift that brings a vector
// below 2^30, and shorter when a vector is zero, since its divisions are then skipped.
// Time goes to the bit-serial divider (twelve divisions, nine planar) and the serial square root
// (31 steps, three roots, two planar), shared under one sequencer.
// The result waits in an output register, and load beats are taken meanwhile; reset is async.
module cubic_spline_frame_evaluator_core
	import csfe_pkg::*;
#(
	parameter int COORD_WIDTH = 24,
	parameter int MAX_STEPS = 63,
	localparam int IN_W = ((3 * COORD_WIDTH + 15) / 8) * 8,
	localparam int OUT_W = ((3 * COORD_WIDTH + 151) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [5:0]       cfg_data,
	input  logic             s_tvalid,
	output logic             s_tready,
	// point_slot, point_x, point_y, point_z, sample_index
	input  logic [IN_W-1:0]  s_tdata,
	// func
	input  logic             s_tuser,
	output logic             m_tvalid,
	input  logic             m_tready,
	// pos_x, pos_y, pos_z, tan_x, tan_y, tan_z, nrm_x, nrm_y, nrm_z, bin_x, bin_y, bin_z
	output logic [OUT_W-1:0] m_tdata
);

	localparam int CW = COORD_WIDTH;
	localparam int CCW = CW + 3;
	localparam int DCW = CW + 4;
	localparam int MAW = (DCW > 31) ? DCW : 31;
	localparam int MBW = 31;
	localparam int PW = MAW + MBW;
	localparam int NW = PW + 1;
	localparam logic [5:0] STEP_CAP = (MAX_STEPS > 63) ? 6'd63 : 6'(MAX_STEPS);
	localparam logic [NW-1:0] POS_LIM = NW'(1) << (CW - 1);

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_PREP1  = 5'd1;
	localparam logic [4:0] S_PREP2  = 5'd2;
	localparam logic [4:0] S_PMUL   = 5'd3;
	localparam logic [4:0] S_PACC   = 5'd4;
	localparam logic [4:0] S_PDIV   = 5'd5;
	localparam logic [4:0] S_PWAIT  = 5'd6;
	localparam logic [4:0] S_NABS   = 5'd7;
	localparam logic [4:0] S_NSHF   = 5'd8;
	localparam logic [4:0] S_NSQM   = 5'd9;
	localparam logic [4:0] S_NSQA   = 5'd10;
	localparam logic [4:0] S_NROOT  = 5'd11;
	localparam logic [4:0] S_NRWAIT = 5'd12;
	localparam logic [4:0] S_NDIV   = 5'd13;
	localparam logic [4:0] S_NDWAIT = 5'd14;
	localparam logic [4:0] S_NDONE  = 5'd15;
	localparam logic [4:0] S_XMUL   = 5'd16;
	localparam logic [4:0] S_XACC   = 5'd17;
	localparam logic [4:0] S_EMIT   = 5'd18;

	localparam logic [1:0] PH_TAN = 2'd0;
	localparam logic [1:0] PH_NRM = 2'd1;
	localparam logic [1:0] PH_BIN = 2'd2;

	logic [4:0] state_q;
	logic [5:0] step_q;
	logic       basis_q;
	logic       planar_q;

	logic signed [CW-1:0]  pt_q [4][3];
	logic signed [CCW-1:0] c_q [4][3];
	logic signed [CCW-1:0] c_nx [4][3];
	logic signed [DCW-1:0] d_q [3][3];
	uvec_t rb_q, tan_q, nrm_q, bin_q, res_q, xa_q, xb_q;

	logic [5:0]  jin_q, s_q, j_q, u_q;
	logic [5:0]  s_c, j_c, u_c;
	logic [11:0] u2_q, j2_q, uj_q, s2_q;
	logic [19:0] w_q [4];
	logic [12:0] dw_q [3];
	logic [20:0] den_q;
	logic [19:0] u2u, u2j, ujj, j2j;
	logic [17:0] s3;

	logic signed [CW-1:0] pos_q [3];
	logic signed [PW-1:0] dir_q [3];
	logic signed [PW-1:0] nv_q [3];
	logic [PW-1:0]        m_q [3];
	logic                 neg_q [3];
	logic signed [PW-1:0] accp_q, accd_q, accx_q, prod_q;
	logic [PW-1:0]        accp_mag;
	logic [SQ_W-1:0]      ss_q;
	logic [ROOT_W-1:0]    len_q;

	logic [1:0] k_q, i_q, phase_q, k1, k2;
	logic [2:0] t_q, td;
	logic       xh_q;

	logic signed [MAW-1:0] ma;
	logic signed [MBW-1:0] mb;

	logic             div_start;
	logic [NW-1:0]    div_num;
	logic [DEN_W-1:0] div_den;
	logic [NW-1:0]    div_quo;
	unit_stat_t       div_stat;
	logic             sq_start;
	logic [ROOT_W-1:0] sq_root;
	unit_stat_t       sq_stat;

	logic              m_tvalid_q;
	logic [OUT_W-1:0]  out_q;
	logic              shift_more;
	logic signed [CW-1:0] pos_c;
	logic [UNIT_W-1:0] qn;

	logic [1:0]          in_slot;
	logic signed [CW-1:0] in_x, in_y, in_z;
	logic [5:0]          in_j;
	logic                take;

	assign in_slot = s_tdata[1:0];
	assign in_x = s_tdata[2 +: CW];
	assign in_y = s_tdata[2 + CW +: CW];
	assign in_z = s_tdata[2 + 2 * CW +: CW];
	assign in_j = s_tdata[2 + 3 * CW +: 6];

	assign s_tready = (state_q == S_IDLE);
	assign take = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = out_q;

	assign k1 = axis_next(k_q);
	assign k2 = axis_next(k1);
	assign td = t_q - 3'd4;

	always_comb begin
		s_c = (step_q == 6'd0) ? 6'd1 : ((step_q > STEP_CAP) ? STEP_CAP : step_q);
		j_c = (jin_q > s_c) ? s_c : jin_q;
		u_c = s_c - j_c;
		u2u = u2_q * u_q;
		u2j = u2_q * j_q;
		ujj = uj_q * j_q;
		j2j = j2_q * j_q;
		s3 = s2_q * s_q;
		for (int k = 0; k < 3; k++) begin
			if (basis_q) begin
				c_nx[0][k] = CCW'(pt_q[0][k]) + (CCW'(pt_q[1][k]) <<< 2) + CCW'(pt_q[2][k]);
				c_nx[1][k] = (CCW'(pt_q[1][k]) <<< 2) + (CCW'(pt_q[2][k]) <<< 1);
				c_nx[2][k] = (CCW'(pt_q[1][k]) <<< 1) + (CCW'(pt_q[2][k]) <<< 2);
				c_nx[3][k] = CCW'(pt_q[1][k]) + (CCW'(pt_q[2][k]) <<< 2) + CCW'(pt_q[3][k]);
			end else begin
				for (int i = 0; i < 4; i++) begin
					c_nx[i][k] = (CCW'(pt_q[i][k]) <<< 2) + (CCW'(pt_q[i][k]) <<< 1);
				end
			end
		end
	end

	always_comb begin
		ma = '0;
		mb = '0;
		unique case (state_q)
			S_PMUL: begin
				if (t_q < 3'd4) begin
					ma = MAW'(c_q[t_q[1:0]][k_q]);
					mb = MBW'(w_q[t_q[1:0]]);
				end else begin
					ma = MAW'(d_q[td[1:0]][k_q]);
					mb = MBW'(dw_q[td[1:0]]);
				end
			end
			S_NSQM: begin
				ma = MAW'(m_q[i_q][30:0]);
				mb = MBW'(m_q[i_q][30:0]);
			end
			S_XMUL: begin
				ma = MAW'(xa_q[xh_q ? k2 : k1]);
				mb = MBW'(xb_q[xh_q ? k1 : k2]);
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	always_comb begin
		accp_mag = accp_q[PW-1] ? PW'(-accp_q) : PW'(accp_q);
		div_start = (state_q == S_PDIV) || ((state_q == S_NDIV) && (len_q != '0));
		if (state_q == S_PDIV) begin
			div_num = {accp_mag, 1'b0} + NW'(den_q);
			div_den = DEN_W'({den_q, 1'b0});
		end else begin
			div_num = NW'({m_q[i_q][29:0], 15'b0}) + NW'(len_q);
			div_den = DEN_W'({len_q, 1'b0});
		end
		sq_start = (state_q == S_NROOT);
		shift_more = (|m_q[0][PW-1:30]) || (|m_q[1][PW-1:30]) || (|m_q[2][PW-1:30]);
		if (accp_q[PW-1]) begin
			pos_c = (div_quo > POS_LIM) ? {1'b1, {(CW-1){1'b0}}} : CW'(NW'(0) - div_quo);
		end else begin
			pos_c = (div_quo > POS_LIM - 1'b1) ? {1'b0, {(CW-1){1'b1}}} : CW'(div_quo);
		end
		qn = (div_quo > NW'(UNIT_ONE)) ? UNIT_W'(UNIT_ONE) : div_quo[UNIT_W-1:0];
	end

	csfe_div #(
		.NUM_W(NW)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.num(div_num),
		.den(div_den),
		.quo(div_quo),
		.stat(div_stat)
	);

	csfe_sqrt u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.start(sq_start),
		.radicand(ss_q),
		.root(sq_root),
		.stat(sq_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q <= 6'd16;
			basis_q <= 1'b0;
			planar_q <= 1'b0;
			rb_q <= '{16'sd0, 16'sd0, UNIT_ONE};
			m_tvalid_q <= 1'b0;
			k_q <= '0;
			t_q <= '0;
			i_q <= '0;
			xh_q <= 1'b0;
			phase_q <= PH_TAN;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_STEP_COUNT: step_q <= cfg_data;
					REG_BASIS_MODE: basis_q <= cfg_data[0];
					REG_PLANAR_MODE: planar_q <= cfg_data[0];
					default: ;
				endcase
			end
			if ((state_q == S_EMIT) && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						if (s_tuser == FUNC_LOAD) begin
							rb_q <= '{16'sd0, 16'sd0, UNIT_ONE};
						end else begin
							state_q <= S_PREP1;
						end
					end
				end
				S_PREP1: state_q <= S_PREP2;
				S_PREP2: begin
					k_q <= '0;
					t_q <= '0;
					state_q <= S_PMUL;
				end
				S_PMUL: state_q <= S_PACC;
				S_PACC: begin
					if (t_q == 3'd6) begin
						state_q <= S_PDIV;
					end else begin
						t_q <= t_q + 3'd1;
						state_q <= S_PMUL;
					end
				end
				S_PDIV: state_q <= S_PWAIT;
				S_PWAIT: begin
					if (div_stat.done) begin
						if (k_q == 2'd2) begin
							phase_q <= PH_TAN;
							state_q <= S_NABS;
						end else begin
							k_q <= k_q + 2'd1;
							t_q <= '0;
							state_q <= S_PMUL;
						end
					end
				end
				S_NABS: state_q <= S_NSHF;
				S_NSHF: begin
					if (!shift_more) begin
						i_q <= '0;
						state_q <= S_NSQM;
					end
				end
				S_NSQM: state_q <= S_NSQA;
				S_NSQA: begin
					if (i_q == 2'd2) begin
						state_q <= S_NROOT;
					end else begin
						i_q <= i_q + 2'd1;
						state_q <= S_NSQM;
					end
				end
				S_NROOT: state_q <= S_NRWAIT;
				S_NRWAIT: begin
					if (sq_stat.done) begin
						i_q <= '0;
						state_q <= S_NDIV;
					end
				end
				S_NDIV: begin
					if (len_q != '0) begin
						state_q <= S_NDWAIT;
					end else if (i_q == 2'd2) begin
						state_q <= S_NDONE;
					end else begin
						i_q <= i_q + 2'd1;
					end
				end
				S_NDWAIT: begin
					if (div_stat.done) begin
						if (i_q == 2'd2) begin
							state_q <= S_NDONE;
						end else begin
							i_q <= i_q + 2'd1;
							state_q <= S_NDIV;
						end
					end
				end
				S_NDONE: begin
					k_q <= '0;
					xh_q <= 1'b0;
					unique case (phase_q)
						PH_TAN: begin
							phase_q <= PH_NRM;
							state_q <= S_XMUL;
						end
						PH_NRM: begin
							if (planar_q) begin
								rb_q <= '{16'sd0, 16'sd0, UNIT_ONE};
								state_q <= S_EMIT;
							end else begin
								phase_q <= PH_BIN;
								state_q <= S_XMUL;
							end
						end
						default: begin
							rb_q <= res_q;
							state_q <= S_EMIT;
						end
					endcase
				end
				S_XMUL: state_q <= S_XACC;
				S_XACC: begin
					xh_q <= ~xh_q;
					if (xh_q && (k_q == 2'd2)) begin
						state_q <= S_NABS;
					end else begin
						if (xh_q) begin
							k_q <= k_q + 2'd1;
						end
						state_q <= S_XMUL;
					end
				end
				S_EMIT: begin
					if (!m_tvalid_q || m_tready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (take) begin
					if (s_tuser == FUNC_LOAD) begin
						pt_q[in_slot][0] <= in_x;
						pt_q[in_slot][1] <= in_y;
						pt_q[in_slot][2] <= in_z;
					end else begin
						jin_q <= in_j;
					end
				end
			end
			S_PREP1: begin
				s_q <= s_c;
				j_q <= j_c;
				u_q <= u_c;
				u2_q <= u_c * u_c;
				j2_q <= j_c * j_c;
				uj_q <= u_c * j_c;
				s2_q <= s_c * s_c;
				c_q <= c_nx;
			end
			S_PREP2: begin
				w_q[0] <= u2u;
				w_q[1] <= (u2j << 1) + u2j;
				w_q[2] <= (ujj << 1) + ujj;
				w_q[3] <= j2j;
				den_q <= (21'(s3) << 2) + (21'(s3) << 1);
				dw_q[0] <= 13'(u2_q);
				dw_q[1] <= {uj_q, 1'b0};
				dw_q[2] <= 13'(j2_q);
				for (int i = 0; i < 3; i++) begin
					for (int k = 0; k < 3; k++) begin
						d_q[i][k] <= DCW'(c_q[i+1][k]) - DCW'(c_q[i][k]);
					end
				end
				accp_q <= '0;
				accd_q <= '0;
			end
			S_PMUL: prod_q <= ma * mb;
			S_PACC: begin
				if (t_q < 3'd4) begin
					accp_q <= accp_q + prod_q;
				end else begin
					accd_q <= accd_q + prod_q;
				end
			end
			S_PDIV: dir_q[k_q] <= accd_q;
			S_PWAIT: begin
				if (div_stat.done) begin
					pos_q[k_q] <= pos_c;
					accp_q <= '0;
					accd_q <= '0;
					if (k_q == 2'd2) begin
						nv_q[0] <= dir_q[0];
						nv_q[1] <= dir_q[1];
						nv_q[2] <= dir_q[2];
					end
				end
			end
			S_NABS: begin
				for (int i = 0; i < 3; i++) begin
					m_q[i] <= nv_q[i][PW-1] ? PW'(-nv_q[i]) : PW'(nv_q[i]);
					neg_q[i] <= nv_q[i][PW-1];
				end
				ss_q <= '0;
			end
			S_NSHF: begin
				if (shift_more) begin
					for (int i = 0; i < 3; i++) begin
						m_q[i] <= m_q[i] >> 1;
					end
				end
			end
			S_NSQM: prod_q <= ma * mb;
			S_NSQA: ss_q <= ss_q + prod_q[SQ_W-1:0];
			S_NRWAIT: begin
				if (sq_stat.done) begin
					len_q <= sq_root;
				end
			end
			S_NDIV: begin
				if (len_q == '0) begin
					res_q[i_q] <= '0;
				end
			end
			S_NDWAIT: begin
				if (div_stat.done) begin
					res_q[i_q] <= neg_q[i_q] ? -unit_t'(qn) : unit_t'(qn);
				end
			end
			S_NDONE: begin
				unique case (phase_q)
					PH_TAN: begin
						tan_q <= res_q;
						if (planar_q) begin
							xa_q <= '{16'sd0, 16'sd0, UNIT_ONE};
						end else begin
							xa_q <= rb_q;
						end
						xb_q <= res_q;
					end
					PH_NRM: begin
						nrm_q <= res_q;
						if (planar_q) begin
							bin_q <= '{16'sd0, 16'sd0, UNIT_ONE};
						end else begin
							xa_q <= tan_q;
							xb_q <= res_q;
						end
					end
					default: bin_q <= res_q;
				endcase
			end
			S_XMUL: prod_q <= ma * mb;
			S_XACC: begin
				if (xh_q) begin
					nv_q[k_q] <= accx_q - prod_q;
				end else begin
					accx_q <= prod_q;
				end
			end
			S_EMIT: begin
				if (!m_tvalid_q || m_tready) begin
					out_q <= OUT_W'({bin_q[2], bin_q[1], bin_q[0],
						nrm_q[2], nrm_q[1], nrm_q[0],
						tan_q[2], tan_q[1], tan_q[0],
						pos_q[2], pos_q[1], pos_q[0]});
				end
			end
			default: ;
		endcase
	end

endmodule

// ----- tb/cubic_spline_frame_evaluator_core_tb.sv -----
module cubic_spline_frame_evaluator_core_tb
	import csfe_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW = 24;
	localparam int IN_W = 80;
	localparam int OUT_W = 216;
	localparam int EVAL_LATENCY = 1500;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	typedef longint vec3_t [3];

	class frame_scoreboard;
		logic [OUT_W-1:0] frame_q [$];
		int mismatches;
		int frames_seen;
		longint pts [4][3];
		vec3_t bprev;
		int unsigned steps;
		bit bspline;
		bit planar;

		function new();
			mismatches = 0;
			frames_seen = 0;
			foreach (pts[i, k]) pts[i][k] = 0;
			bprev = '{0, 0, 16384};
			steps = 16;
			bspline = 0;
			planar = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [5:0] v);
			case (idx)
				REG_STEP_COUNT: steps = 32'(v);
				REG_BASIS_MODE: bspline = v[0];
				REG_PLANAR_MODE: planar = v[0];
				default: ;
			endcase
		endfunction

		function longint unsigned root64(longint unsigned x);
			longint unsigned res, b;
			res = 0;
			b = 64'd1 << 62;
			while (b > x) b >>= 2;
			while (b != 0) begin
				if (x >= res + b) begin
					x -= res + b;
					res = (res >> 1) + b;
				end else begin
					res >>= 1;
				end
				b >>= 2;
			end
			return res;
		endfunction

		function void unit_vec(input vec3_t v, output vec3_t r);
			longint unsigned m [3];
			longint unsigned mx, len, q;
			for (int i = 0; i < 3; i++) m[i] = v[i] < 0 ? -v[i] : v[i];
			mx = (m[0] > m[1]) ? m[0] : m[1];
			mx = (m[2] > mx) ? m[2] : mx;
			while (mx >= (64'd1 << 30)) begin
				for (int i = 0; i < 3; i++) m[i] >>= 1;
				mx >>= 1;
			end
			len = root64(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
			for (int i = 0; i < 3; i++) begin
				if (len == 0) begin
					r[i] = 0;
				end else begin
					q = (2 * m[i] * 16384 + len) / (2 * len);
					if (q > 16384) q = 16384;
					r[i] = v[i] < 0 ? -longint'(q) : longint'(q);
				end
			end
		endfunction

		function void cross3(input vec3_t a, input vec3_t b, output vec3_t r);
			r[0] = a[1] * b[2] - a[2] * b[1];
			r[1] = a[2] * b[0] - a[0] * b[2];
			r[2] = a[0] * b[1] - a[1] * b[0];
		endfunction

		function void note_beat(logic func, logic [IN_W-1:0] d);
			longint c [4][3];
			vec3_t dir, tng, nrm, bin, tmp;
			longint s, j, u, w0, w1, w2, w3, den, n, p, lim;
			longint unsigned mg;
			logic [OUT_W-1:0] f;
			if (func == FUNC_LOAD) begin
				for (int k = 0; k < 3; k++)
					pts[d[1:0]][k] = longint'($signed(d[2 + CW*k +: CW]));
				bprev = '{0, 0, 16384};
				return;
			end
			s = steps;
			if (s > 63) s = 63;
			if (s < 1) s = 1;
			j = 64'(d[79:74]);
			if (j > s) j = s;
			u = s - j;
			for (int k = 0; k < 3; k++) begin
				if (bspline) begin
					c[0][k] = pts[0][k] + 4 * pts[1][k] + pts[2][k];
					c[1][k] = 4 * pts[1][k] + 2 * pts[2][k];
					c[2][k] = 2 * pts[1][k] + 4 * pts[2][k];
					c[3][k] = pts[1][k] + 4 * pts[2][k] + pts[3][k];
				end else begin
					for (int i = 0; i < 4; i++) c[i][k] = 6 * pts[i][k];
				end
			end
			w0 = u * u * u;
			w1 = 3 * u * u * j;
			w2 = 3 * u * j * j;
			w3 = j * j * j;
			den = 6 * s * s * s;
			lim = 64'sd1 << (CW - 1);
			for (int k = 0; k < 3; k++) begin
				n = w0 * c[0][k] + w1 * c[1][k] + w2 * c[2][k] + w3 * c[3][k];
				mg = n < 0 ? -n : n;
				mg = (2 * mg + den) / (2 * den);
				p = n < 0 ? -longint'(mg) : longint'(mg);
				if (p > lim - 1) p = lim - 1;
				if (p < -lim) p = -lim;
				f[CW*k +: CW] = p[CW-1:0];
				dir[k] = u * u * (c[1][k] - c[0][k]) + 2 * u * j * (c[2][k] - c[1][k])
					+ j * j * (c[3][k] - c[2][k]);
			end
			unit_vec(dir, tng);
			if (planar) begin
				bin = '{0, 0, 16384};
				cross3(bin, tng, tmp);
				unit_vec(tmp, nrm);
			end else begin
				cross3(bprev, tng, tmp);
				unit_vec(tmp, nrm);
				cross3(tng, nrm, tmp);
				unit_vec(tmp, bin);
			end
			bprev = bin;
			for (int k = 0; k < 3; k++) begin
				f[72 + 16*k +: 16] = tng[k][15:0];
				f[120 + 16*k +: 16] = nrm[k][15:0];
				f[168 + 16*k +: 16] = bin[k][15:0];
			end
			frame_q = {frame_q, f};
		endfunction

		function void check_result(logic [OUT_W-1:0] got);
			logic [OUT_W-1:0] e;
			int w, o;
			bit bad;
			frames_seen++;
			if (frame_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result beat %h", got);
				return;
			end
			e = frame_q.pop_front();
			bad = 0;
			for (int fi = 0; fi < 12; fi++) begin
				w = fi < 3 ? CW : 16;
				o = fi < 3 ? CW * fi : 72 + 16 * (fi - 3);
				if ((got >> o) % (1 << w) != (e >> o) % (1 << w)) begin
					bad = 1;
					if (mismatches < 10)
						$display("result %0d field %0d: expected %h, got %h", frames_seen, fi,
							(e >> o) % (1 << w), (got >> o) % (1 << w));
				end
			end
			if (bad) mismatches++;
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [1:0] cfg_index = '0;
	logic [5:0] cfg_data = '0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic s_tuser = 0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [OUT_W-1:0] m_tdata;

	frame_scoreboard sb = new();
	int hold_cycles = 0;
	bit hold_done = 0;
	bit planar_pts = 0;
	int cur_steps = 16;

	cubic_spline_frame_evaluator_core DUT (.*);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("FAIL");
		$finish;
	end

	task automatic push_beat(logic func, logic [1:0] slot, logic [CW-1:0] x, logic [CW-1:0] y,
			logic [CW-1:0] z, logic [5:0] j);
		int g;
		s_tvalid <= 1;
		s_tuser <= func;
		s_tdata <= {j, z, y, x, slot};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_beat(func, {j, z, y, x, slot});
		if ($urandom_range(0, 3) == 0) begin
			g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 5);
			s_tvalid <= 0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic cfg_write(logic [1:0] idx, logic [5:0] v);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		sb.write_reg(idx, v);
		cfg_we <= 0;
		@(posedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 0;
		while (sb.frame_q.size() != 0) @(posedge clk);
		repeat (EVAL_LATENCY) @(posedge clk);
	endtask

	function automatic logic [CW-1:0] rand_coord();
		case ($urandom_range(0, 3))
			0: return CW'($urandom);
			1: return $urandom_range(0, 1) ? CW'($urandom_range(0, 65535))
				: -CW'($urandom_range(0, 65535));
			2: return {1'b0, {(CW-1){1'b1}}};
			default: return CW'($urandom_range(0, 8191)) - CW'(4096);
		endcase
	endfunction

	task automatic load_point(logic [1:0] slot);
		logic [CW-1:0] z;
		z = (planar_pts && $urandom_range(0, 7) != 0) ? '0 : rand_coord();
		push_beat(FUNC_LOAD, slot, rand_coord(), rand_coord(), z, 6'($urandom));
	endtask

	task automatic eval_sample(int j);
		push_beat(FUNC_EVAL, 2'($urandom), CW'($urandom), CW'($urandom), CW'($urandom), j[5:0]);
	endtask

	task automatic random_items(int n);
		int cnt, ne, j0;
		logic [CW-1:0] x, y, z;
		cnt = 0;
		while (cnt < n) begin
			case ($urandom_range(0, 9))
				0: begin
					x = rand_coord();
					y = rand_coord();
					z = planar_pts ? '0 : rand_coord();
					for (int i = 0; i < 4; i++)
						push_beat(FUNC_LOAD, 2'(i), x, y, z, 6'($urandom));
					eval_sample($urandom_range(0, 63));
					eval_sample($urandom_range(0, 63));
					cnt += 6;
				end
				1: begin
					load_point(2'($urandom));
					cnt++;
				end
				2: begin
					eval_sample($urandom_range(0, 63));
					cnt++;
				end
				default: begin
					if ($urandom_range(0, 1)) begin
						for (int i = 0; i < 4; i++) load_point(2'(i));
					end else begin
						for (int i = 3; i >= 0; i--) load_point(2'(i));
					end
					ne = $urandom_range(1, 5);
					j0 = $urandom_range(0, cur_steps);
					for (int i = 0; i < ne; i++)
						eval_sample((i == ne - 1 && $urandom_range(0, 4) == 0)
							? $urandom_range(0, 63) : (j0 + i) % 64);
					cnt += 4 + ne;
				end
			endcase
		end
	endtask

	initial begin
		int mode, left;
		mode = 0;
		left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) sb.check_result(m_tdata);
			if (!hold_done && sb.frames_seen == 60) begin
				hold_done = 1;
				hold_cycles = 6000;
			end
			if (left == 0) begin
				mode = $urandom_range(0, 2);
				left = $urandom_range(100, 600);
			end
			left--;
			if (hold_cycles > 0) begin
				hold_cycles--;
				m_tready <= 0;
			end else begin
				case (mode)
					0: m_tready <= 1;
					1: m_tready <= $urandom_range(0, 1);
					default: m_tready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	initial begin
		int ph_steps [5] = '{63, 0, 1, 5, 16};
		int ph_basis [5] = '{1, 0, 1, 1, 0};
		int ph_planar [5] = '{0, 1, 1, 0, 0};
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		push_beat(FUNC_LOAD, 2'd0, 24'h7fffff, 24'h7fffff, 24'h7fffff, 6'h3f);
		push_beat(FUNC_LOAD, 2'd1, 24'h800000, 24'h800000, 24'h800000, 6'h00);
		push_beat(FUNC_LOAD, 2'd2, 24'h000000, 24'h7fffff, 24'h800000, 6'h15);
		push_beat(FUNC_LOAD, 2'd3, 24'h800000, 24'h000000, 24'h7fffff, 6'h2a);
		eval_sample(0);
		eval_sample(8);
		eval_sample(16);
		eval_sample(63);
		eval_sample(17);
		for (int i = 0; i < 4; i++)
			push_beat(FUNC_LOAD, 2'(i), 24'h001000, 24'hfff000, 24'h000800, 6'h3f);
		eval_sample(3);
		eval_sample(4);
		push_beat(FUNC_LOAD, 2'd1, 24'h002000, 24'h000000, 24'h000000, 6'h00);
		eval_sample(5);
		eval_sample(6);
		eval_sample(16);
		random_items(250);

		for (int p = 0; p < 5; p++) begin
			drain();
			cfg_write(REG_STEP_COUNT, 6'(ph_steps[p]));
			cfg_write(REG_BASIS_MODE, 6'(ph_basis[p]));
			cfg_write(REG_PLANAR_MODE, 6'(ph_planar[p]));
			if (p == 3) cfg_write(REG_UNUSED, 6'h3f);
			cur_steps = ph_steps[p] == 0 ? 1 : ph_steps[p];
			planar_pts = ph_planar[p] != 0;
			random_items(235);
		end

		s_tvalid <= 0;
		while (sb.frame_q.size() != 0) @(posedge clk);
		repeat (EVAL_LATENCY) @(posedge clk);
		if (sb.mismatches == 0 && sb.frame_q.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
